### src/wrmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted running mean and variance: shared package
// Widths, constants and the request and response types that connect the
// sequencer to the shared multiply and divide unit.
// ----------------------------------------------------------------------------
package wrmv_pkg;

  localparam int unsigned ACC_W     = 64;
  localparam int unsigned WIDE_W    = 2 * ACC_W;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned MINW_W    = 17;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [MINW_W-1:0] MINW_RESET = MINW_W'(7);

  typedef struct packed {
    logic              start;
    logic              div;
    logic [WIDE_W-1:0] a;
    logic [ACC_W-1:0]  b;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [WIDE_W-1:0] res;
  } unit_rsp_t;

endpackage

### src/wrmv_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted running mean and variance: shared multiply and divide unit
// Shift-add multiply, one multiplier bit per cycle, and restoring divide of a
// 128-bit dividend by a 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrmv_muldiv import wrmv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_e;

  ustate_e           st_q;
  logic [WIDE_W-1:0] r_q;
  logic [WIDE_W-1:0] a_q;
  logic [ACC_W-1:0]  b_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;

  logic [ACC_W:0]    trial;
  logic [ACC_W:0]    diff;
  logic              fits;
  logic [ACC_W-1:0]  rem_nx;

  // The partial remainder sits in the upper half of r_q and the quotient
  // bits shift into the lower half as the dividend bits shift out.
  assign trial  = {r_q[WIDE_W-1:ACC_W], r_q[ACC_W-1]};
  assign diff   = trial - {1'b0, b_q};
  assign fits   = (trial >= {1'b0, b_q});
  assign rem_nx = fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
      r_q    <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        U_IDLE: begin
          if (req_i.start) begin
            a_q <= req_i.a;
            b_q <= req_i.b;
            if (req_i.div) begin
              r_q   <= req_i.a;
              cnt_q <= STEP_W'(DIV_STEPS);
              st_q  <= U_DIV;
            end else begin
              r_q  <= '0;
              st_q <= U_MUL;
            end
          end
        end
        U_MUL: begin
          if (b_q == '0) begin
            st_q   <= U_IDLE;
            done_q <= 1'b1;
          end else begin
            r_q <= r_q + (b_q[0] ? a_q : '0);
            a_q <= a_q << 1;
            b_q <= b_q >> 1;
          end
        end
        U_DIV: begin
          r_q   <= {rem_nx, r_q[ACC_W-2:0], fits};
          cnt_q <= cnt_q - STEP_W'(1);
          if (cnt_q == STEP_W'(1)) begin
            st_q   <= U_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (st_q != U_IDLE);
  assign rsp_o.res  = r_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (st_q == U_IDLE))
    else $error("Operation started while the unit is busy.");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && req_i.div) |-> (req_i.a[WIDE_W-1:ACC_W] < req_i.b))
    else $error("Division started with a quotient wider than 64 bits.");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q != U_IDLE))
    else $error("Done raised without a running operation.");
`endif

endmodule

### src/weighted_running_mean_variance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted running mean and variance
// Incremental weighted mean and variance with min, max, count and weight sum.
// ----------------------------------------------------------------------------
// Each input transaction carries one sample and its weight; weights below the
// weight floor register are raised to it. The block takes one sample at a time
// and holds in_stall_o high while it works on it. The first sample after reset
// does not use the shared unit. Every later sample with a nonzero weight sum
// runs through one shared unit that retires one multiplier bit or one quotient
// bit per cycle: four multiplies of up to 32 or VALUE_WIDTH+1 bits and up to
// three 64-step divisions. The result sits in an output register, so the next
// sample is taken while a result waits to be taken. The user must write the
// weight floor only while the block is idle; the block does not enforce it.
module weighted_running_mean_variance import wrmv_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          weight_floor_we_i,
  input  logic [MINW_W-1:0]             weight_floor_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [WEIGHT_W-1:0]           weight_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] mean_o,
  output logic [ACC_W-1:0]              variance_o,
  output logic signed [VALUE_WIDTH-1:0] min_seen_o,
  output logic signed [VALUE_WIDTH-1:0] max_seen_o,
  output logic [COUNT_W-1:0]            sample_count_o,
  output logic [ACC_W-1:0]              weight_total_o,
  output logic                          saturated_o
);

  localparam int unsigned V = VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_MUL3, S_MUL4,
    S_VAR, S_DIV3, S_OUT
  } state_e;

  state_e                st_q;
  logic                  start_q;
  logic [MINW_W-1:0]     minw_q;

  logic signed [V-1:0]   val_q;
  logic [WEIGHT_W-1:0]   w_q;
  logic signed [V-1:0]   mean_q;
  logic [ACC_W-1:0]      sum_q;
  logic [ACC_W-1:0]      m2_q;
  logic [COUNT_W-1:0]    cnt_q;
  logic signed [V-1:0]   min_q;
  logic signed [V-1:0]   max_q;
  logic                  sat_q;
  logic [ACC_W-1:0]      ns_q;
  logic [V:0]            ad_q;
  logic                  neg_q;
  logic [V:0]            step_q;
  logic [ACC_W-1:0]      var_q;

  logic                  out_valid_q;
  logic signed [V-1:0]   out_mean_q;
  logic [ACC_W-1:0]      out_var_q;
  logic signed [V-1:0]   out_min_q;
  logic signed [V-1:0]   out_max_q;
  logic [COUNT_W-1:0]    out_cnt_q;
  logic [ACC_W-1:0]      out_sum_q;
  logic                  out_sat_q;

  unit_req_t             req;
  unit_rsp_t             rsp;

  logic [WEIGHT_W-1:0]   w_eff;
  logic [ACC_W:0]        ns_sum;
  logic [ACC_W-1:0]      ns_val;
  logic [V:0]            diff;
  logic [V:0]            ad_val;
  logic [WIDE_W-1:0]     t_sh;
  logic                  t_hi;
  logic [ACC_W:0]        m2_sum;
  logic [V:0]            mean_nx;
  logic                  var_ovf;
  logic                  accept;

  assign accept  = in_valid_i && (st_q == S_IDLE);
  assign w_eff   = (weight_i < WEIGHT_W'(minw_q)) ? WEIGHT_W'(minw_q) : weight_i;
  assign ns_sum  = {1'b0, sum_q} + (ACC_W + 1)'(w_q);
  assign ns_val  = ns_sum[ACC_W] ? '1 : ns_sum[ACC_W-1:0];
  assign diff    = {val_q[V-1], val_q} - {mean_q[V-1], mean_q};
  assign ad_val  = diff[V] ? (~diff + (V + 1)'(1)) : diff;
  assign t_sh    = rsp.res >> FRAC_BITS;
  assign t_hi    = |t_sh[WIDE_W-1:ACC_W];
  assign m2_sum  = {1'b0, m2_q} + {1'b0, t_sh[ACC_W-1:0]};
  assign mean_nx = neg_q ? ({mean_q[V-1], mean_q} - step_q)
                         : ({mean_q[V-1], mean_q} + step_q);
  assign var_ovf = ((m2_q >> (ACC_W - FRAC_BITS)) >= sum_q);

  always_comb begin
    req.start = start_q;
    req.div   = 1'b0;
    req.a     = '0;
    req.b     = '0;
    unique case (st_q)
      S_MUL1: begin
        req.a = WIDE_W'(ad_q);
        req.b = ACC_W'(w_q);
      end
      S_DIV1: begin
        req.div = 1'b1;
        req.a   = rsp.res;
        req.b   = ns_q;
      end
      S_MUL2: begin
        req.a = WIDE_W'(sum_q);
        req.b = ACC_W'(w_q);
      end
      S_DIV2: begin
        req.div = 1'b1;
        req.a   = rsp.res;
        req.b   = ns_q;
      end
      S_MUL3: begin
        req.a = WIDE_W'(rsp.res[ACC_W-1:0]);
        req.b = ACC_W'(ad_q);
      end
      S_MUL4: begin
        req.a = t_sh;
        req.b = ACC_W'(ad_q);
      end
      S_DIV3: begin
        req.div = 1'b1;
        req.a   = WIDE_W'(m2_q) << FRAC_BITS;
        req.b   = sum_q;
      end
      default: begin
        req.a = '0;
      end
    endcase
  end

  wrmv_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minw_q <= MINW_RESET;
    end else if (weight_floor_we_i) begin
      minw_q <= weight_floor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      start_q     <= 1'b0;
      val_q       <= '0;
      w_q         <= '0;
      mean_q      <= '0;
      sum_q       <= '0;
      m2_q        <= '0;
      cnt_q       <= '0;
      min_q       <= {1'b0, {(V - 1){1'b1}}};
      max_q       <= {1'b1, {(V - 1){1'b0}}};
      sat_q       <= 1'b0;
      ns_q        <= '0;
      ad_q        <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
      out_mean_q  <= '0;
      out_var_q   <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      out_cnt_q   <= '0;
      out_sum_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if ((st_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (accept) begin
            val_q <= value_i;
            w_q   <= w_eff;
            st_q  <= S_PREP;
          end
        end
        S_PREP: begin
          if (val_q < min_q) begin
            min_q <= val_q;
          end
          if (val_q > max_q) begin
            max_q <= val_q;
          end
          if (cnt_q == '1) begin
            sat_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + COUNT_W'(1);
          end
          if (cnt_q == '0) begin
            mean_q <= val_q;
            sum_q  <= ACC_W'(w_q);
            m2_q   <= '0;
            st_q   <= S_VAR;
          end else begin
            ns_q  <= ns_val;
            ad_q  <= ad_val;
            neg_q <= diff[V];
            if (ns_sum[ACC_W]) begin
              sat_q <= 1'b1;
            end
            if (ns_val == '0) begin
              sum_q <= ns_val;
              st_q  <= S_VAR;
            end else begin
              start_q <= 1'b1;
              st_q    <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (rsp.done) begin
            start_q <= 1'b1;
            st_q    <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (rsp.done) begin
            step_q  <= rsp.res[V:0];
            start_q <= 1'b1;
            st_q    <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (rsp.done) begin
            start_q <= 1'b1;
            st_q    <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (rsp.done) begin
            start_q <= 1'b1;
            st_q    <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (rsp.done) begin
            start_q <= 1'b1;
            st_q    <= S_MUL4;
          end
        end
        S_MUL4: begin
          if (rsp.done) begin
            mean_q <= mean_nx[V-1:0];
            sum_q  <= ns_q;
            if (t_hi || m2_sum[ACC_W]) begin
              m2_q  <= '1;
              sat_q <= 1'b1;
            end else begin
              m2_q <= m2_sum[ACC_W-1:0];
            end
            st_q <= S_VAR;
          end
        end
        S_VAR: begin
          if ((cnt_q >= COUNT_W'(2)) && (sum_q != '0)) begin
            if (var_ovf) begin
              var_q <= '1;
              st_q  <= S_OUT;
            end else begin
              start_q <= 1'b1;
              st_q    <= S_DIV3;
            end
          end else begin
            var_q <= '0;
            st_q  <= S_OUT;
          end
        end
        S_DIV3: begin
          if (rsp.done) begin
            var_q <= rsp.res[ACC_W-1:0];
            st_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_mean_q  <= mean_q;
            out_var_q   <= var_q;
            out_min_q   <= min_q;
            out_max_q   <= max_q;
            out_cnt_q   <= cnt_q;
            out_sum_q   <= sum_q;
            out_sat_q   <= sat_q;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (st_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign mean_o         = out_mean_q;
  assign variance_o     = out_var_q;
  assign min_seen_o     = out_min_q;
  assign max_seen_o     = out_max_q;
  assign sample_count_o = out_cnt_q;
  assign weight_total_o = out_sum_q;
  assign saturated_o    = out_sat_q;

`ifndef SYNTH
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_seen_o <= max_seen_o))
    else $error("Reported minimum exceeds reported maximum.");

  a_mean_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((min_seen_o <= mean_o) && (mean_o <= max_seen_o)))
    else $error("Reported mean lies outside the seen value range.");

  a_var_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (sample_count_o < COUNT_W'(2))) |-> (variance_o == '0))
    else $error("Nonzero variance reported before the second sample.");

  a_count_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0))
    else $error("Result transaction reported with a zero sample count.");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for weighted_running_mean_variance
// Samples are fed from a queue through a valid/stall driver. Each accepted
// sample updates a local fixed point model of the weighted mean, M2, weight
// sum, count, min, max and saturation flag. A monitor compares every result
// transaction field by field with the oldest predicted result. The run goes
// through several weight floor settings, including zero, the range limits and
// a value beyond the range, random idling on both sides, one long output
// stall, and a final burst of wide values and heavy weights that saturates M2.
// ----------------------------------------------------------------------------
module tb;
  import wrmv_pkg::*;

  localparam int VW = 32;
  localparam int FB = 16;

  typedef struct packed {
    logic [VW-1:0]       value;
    logic [WEIGHT_W-1:0] weight;
  } sample_t;

  typedef struct packed {
    logic [VW-1:0]      mean;
    logic [ACC_W-1:0]   variance;
    logic [VW-1:0]      min_seen;
    logic [VW-1:0]      max_seen;
    logic [COUNT_W-1:0] sample_count;
    logic [ACC_W-1:0]   weight_total;
    logic               saturated;
  } stats_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 weight_floor_we_i = 1'b0;
  logic [MINW_W-1:0]    weight_floor_i = MINW_RESET;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [VW-1:0] value_i = '0;
  logic [WEIGHT_W-1:0]  weight_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [VW-1:0] mean_o;
  logic [ACC_W-1:0]     variance_o;
  logic signed [VW-1:0] min_seen_o;
  logic signed [VW-1:0] max_seen_o;
  logic [COUNT_W-1:0]   sample_count_o;
  logic [ACC_W-1:0]     weight_total_o;
  logic                 saturated_o;

  sample_t pending_samples[$];
  stats_t  expected_stats[$];
  sample_t offered;
  int      error_count = 0;
  int      results_seen = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  bit      calm = 1'b0;

  logic signed [63:0] acc_mean = '0;
  logic [63:0]        acc_weight = '0;
  logic [63:0]        acc_m2 = '0;
  logic [31:0]        acc_count = '0;
  logic signed [63:0] acc_low = (64'sd1 <<< (VW - 1)) - 64'sd1;
  logic signed [63:0] acc_high = -(64'sd1 <<< (VW - 1));
  logic               acc_sat = 1'b0;
  logic [MINW_W-1:0]  cfg_weight_floor = MINW_RESET;

  weighted_running_mean_variance #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS  (FB)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .weight_floor_we_i(weight_floor_we_i),
    .weight_floor_i   (weight_floor_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_i          (value_i),
    .weight_i         (weight_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mean_o           (mean_o),
    .variance_o       (variance_o),
    .min_seen_o       (min_seen_o),
    .max_seen_o       (max_seen_o),
    .sample_count_o   (sample_count_o),
    .weight_total_o   (weight_total_o),
    .saturated_o      (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic stats_t update_stats(sample_t s);
    logic signed [63:0] v;
    logic signed [63:0] d;
    logic [63:0]        w;
    logic [63:0]        prev;
    logic [63:0]        ns;
    logic [63:0]        ad;
    logic [63:0]        step;
    logic [63:0]        h;
    logic [63:0]        m2_next;
    logic [127:0]       t;
    logic [127:0]       q;
    stats_t             r;
    v = {{(64 - VW){s.value[VW-1]}}, s.value};
    w = 64'(s.weight);
    if (w < 64'(cfg_weight_floor)) w = 64'(cfg_weight_floor);
    if (v < acc_low) acc_low = v;
    if (v > acc_high) acc_high = v;
    if (acc_count == 0) begin
      acc_mean = v;
      acc_weight = w;
      acc_m2 = '0;
    end else begin
      prev = acc_weight;
      ns = prev + w;
      if (ns < prev) begin
        ns = '1;
        acc_sat = 1'b1;
      end
      // With a zero weight sum the mean and M2 stay where they are.
      if (ns != 0) begin
        d = v - acc_mean;
        ad = d[63] ? 64'(-d) : 64'(d);
        t = ({64'b0, w} * {64'b0, ad}) / {64'b0, ns};
        step = t[63:0];
        t = ({64'b0, prev} * {64'b0, w}) / {64'b0, ns};
        h = t[63:0];
        t = ({64'b0, h} * {64'b0, ad}) >> FB;
        t = (t * {64'b0, ad}) >> FB;
        if (d[63]) acc_mean = acc_mean - $signed(step);
        else acc_mean = acc_mean + $signed(step);
        m2_next = acc_m2 + t[63:0];
        if (t[127:64] != 0 || m2_next < acc_m2) begin
          acc_m2 = '1;
          acc_sat = 1'b1;
        end else begin
          acc_m2 = m2_next;
        end
      end
      acc_weight = ns;
    end
    if (acc_count == '1) acc_sat = 1'b1;
    else acc_count = acc_count + 1;
    r.variance = '0;
    if (acc_count >= 2 && acc_weight != 0) begin
      q = ({64'b0, acc_m2} << FB) / {64'b0, acc_weight};
      r.variance = (q[127:64] != 0) ? '1 : q[63:0];
    end
    r.mean = acc_mean[VW-1:0];
    r.min_seen = acc_low[VW-1:0];
    r.max_seen = acc_high[VW-1:0];
    r.sample_count = acc_count;
    r.weight_total = acc_weight;
    r.saturated = acc_sat;
    return r;
  endfunction

  task automatic check_stats(stats_t got);
    stats_t e;
    if (expected_stats.size() == 0) begin
      $error("result transaction with no sample waiting for it");
      error_count++;
    end else begin
      e = expected_stats.pop_front();
      if (got.mean !== e.mean) begin
        $error("mean: expected %h, got %h", e.mean, got.mean);
        error_count++;
      end
      if (got.variance !== e.variance) begin
        $error("variance: expected %h, got %h", e.variance, got.variance);
        error_count++;
      end
      if (got.min_seen !== e.min_seen) begin
        $error("min_seen: expected %h, got %h", e.min_seen, got.min_seen);
        error_count++;
      end
      if (got.max_seen !== e.max_seen) begin
        $error("max_seen: expected %h, got %h", e.max_seen, got.max_seen);
        error_count++;
      end
      if (got.sample_count !== e.sample_count) begin
        $error("sample_count: expected %h, got %h", e.sample_count, got.sample_count);
        error_count++;
      end
      if (got.weight_total !== e.weight_total) begin
        $error("weight_total: expected %h, got %h", e.weight_total, got.weight_total);
        error_count++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %b, got %b", e.saturated, got.saturated);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_stats.push_back(update_stats(offered));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          offered = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          value_i <= offered.value;
          weight_i <= offered.weight;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_stats('{mean_o, variance_o, min_seen_o, max_seen_o, sample_count_o,
                      weight_total_o, saturated_o});
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen == 150) begin
        hold_done = 1'b1;
        hold_left = 3000;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  task automatic offer(logic [VW-1:0] v, logic [WEIGHT_W-1:0] w);
    sample_t s;
    s.value = v;
    s.weight = w;
    pending_samples.push_back(s);
  endtask

  task automatic set_weight_floor(logic [MINW_W-1:0] mw);
    @(posedge clk_i);
    weight_floor_we_i <= 1'b1;
    weight_floor_i <= mw;
    cfg_weight_floor = mw;
    @(posedge clk_i);
    weight_floor_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_stats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_phase(int n, bit heavy);
    int          center;
    int unsigned spread;
    int unsigned pick;
    center = $urandom;
    spread = $urandom_range(4, 24);
    repeat (n) begin
      pick = $urandom_range(99);
      if (heavy) begin
        offer($urandom, (pick < 20) ? 32'hFFFF_FFFF : 32'($urandom));
      end else if (pick < 88) begin
        offer(center + (int'($urandom) >>> (32 - spread)),
              $urandom >> $urandom_range(8, 31));
      end else begin
        offer($urandom, $urandom_range(3));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A zero floor with zero weights is the only way to keep the sum at zero.
    set_weight_floor('0);
    offer(32'h0001_0000, 32'h0);
    offer(32'hFFFB_0000, 32'h0);
    offer(32'h7FFF_FFFF, 32'h0);
    drain();

    set_weight_floor(MINW_W'(1));
    offer(32'h8000_0000, 32'h0);
    offer(32'h0000_0000, 32'h1);
    offer(32'hFFFF_FFFF, 32'h2);
    offer(32'h7FFF_FFFF, 32'h3);
    offer(32'h0002_8000, 32'h0001_0000);
    drain();

    set_weight_floor(MINW_W'(65536));
    offer(32'h0003_0000, 32'h0);
    offer(32'hFFFD_4000, 32'h0000_FFFF);
    offer(32'h0000_C000, 32'h0001_0000);
    offer(32'h0010_0000, 32'h0001_0001);
    drain();

    set_weight_floor('1);
    offer(32'hFFFE_0000, 32'h0001_FFFE);
    offer(32'h0001_0000, 32'h0002_0000);
    drain();

    set_weight_floor(MINW_RESET);
    offer(32'h0000_1234, 32'h6);
    offer(32'h0000_1234, 32'h7);
    offer(32'hFFFF_B000, 32'h8);
    offer(32'h0000_0000, 32'h0001_0000);
    drain();

    for (int p = 0; p < 5; p++) begin
      set_weight_floor((p == 3) ? MINW_RESET : MINW_W'($urandom_range(1, 65536)));
      calm = (p == 2);
      queue_phase(230, 1'b0);
      drain();
    end
    calm = 1'b0;

    set_weight_floor(MINW_W'(1));
    queue_phase(150, 1'b1);
    drain();
    repeat (400) @(posedge clk_i);

    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
src/wrmv_pkg.sv
src/wrmv_muldiv.sv
src/weighted_running_mean_variance.sv
tb/sv/tb.sv
